[hdl/ptr_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse trigger resampler package
// Shared sizes, constants and enumerations for the resampler block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

  // Store depth, number of points per pulse and sample width.
  localparam int MaxPulse   = 4096;
  localparam int OutPoints  = 64;
  localparam int SampleBits = 16;

  // Derived widths.
  localparam int StoreAw = $clog2(MaxPulse);
  localparam int RunW    = StoreAw + 1;
  localparam int IdxW    = $clog2(OutPoints);
  localparam int Den     = OutPoints - 1;

  // Division by 63 through a reciprocal, exact for values below 2**30.
  localparam logic [30:0] Recip63    = 31'd1090785346;
  localparam int          RecipShift = 36;

  // Timestamp divider: (8*t + 25) / 50 on a 36 bit numerator.
  localparam int TimeNumW = 36;
  localparam int TimeOutW = 30;

  // Division by 25 through a reciprocal, exact for values below 2**35.
  localparam logic [35:0] Recip25      = 36'd43980465112;
  localparam int          Recip25Shift = 40;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_HYSTERESIS  = 2'd1,
    REG_MASS_FACTOR = 2'd2,
    REG_START_TIME  = 2'd3
  } reg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_MIX,
    S_SCALE,
    S_RECIP,
    S_PUT
  } seq_state_t;

endpackage

`default_nettype wire

[hdl/ptr_store.sv]
// ----------------------------------------------------------------------------
// Pulse sample store
// One write port and two registered read ports over the pulse buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_store (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic        [ptr_pkg::StoreAw-1:0]     waddr,
  input  wire logic signed [ptr_pkg::SampleBits-1:0]  wdata,
  input  wire logic        [ptr_pkg::StoreAw-1:0]     raddr_a,
  input  wire logic        [ptr_pkg::StoreAw-1:0]     raddr_b,
  output logic signed      [ptr_pkg::SampleBits-1:0]  rdata_a,
  output logic signed      [ptr_pkg::SampleBits-1:0]  rdata_b
);

  logic signed [ptr_pkg::SampleBits-1:0] mem [ptr_pkg::MaxPulse];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hdl/ptr_div50.sv]
// ----------------------------------------------------------------------------
// Divide by fifty
// Pipelined reciprocal multiplication for the timestamp scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_div50 (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [ptr_pkg::TimeNumW-1:0]      dividend,
  output logic                                   done,
  output logic      [ptr_pkg::TimeOutW-1:0]      quotient
);

  logic [34:0] y;
  logic        v1;
  logic        v2;
  logic        v3;
  logic [35:0] p_hh;
  logic [35:0] p_hl;
  logic [34:0] p_lh;
  logic [34:0] p_ll;
  logic [35:0] hh_d;
  logic [54:0] mid;
  logic [70:0] total;

  // Stage valid bits; done pulses when the quotient register is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Dividing by fifty is halving and then dividing by 25.
  always_ff @(posedge clk) begin
    if (start) begin
      y <= dividend[ptr_pkg::TimeNumW-1:1];
    end
  end

  // Four partial products of the halved value and the reciprocal.
  always_ff @(posedge clk) begin
    p_hh <= y[34:17] * ptr_pkg::Recip25[35:18];
    p_hl <= y[34:17] * ptr_pkg::Recip25[17:0];
    p_lh <= y[16:0]  * ptr_pkg::Recip25[35:18];
    p_ll <= y[16:0]  * ptr_pkg::Recip25[17:0];
  end

  // The middle terms are summed first, the top term in the cycle after.
  always_ff @(posedge clk) begin
    mid  <= {2'b00, p_hl, 17'd0} + {2'b00, p_lh, 18'd0} + {20'd0, p_ll};
    hh_d <= p_hh;
  end

  always_comb begin
    total = {hh_d, 35'd0} + {16'd0, mid};
  end

  always_ff @(posedge clk) begin
    quotient <= total[ptr_pkg::Recip25Shift +: ptr_pkg::TimeOutW];
  end

endmodule

`default_nettype wire

[hdl/pulse_trigger_resampler_unit.sv]
// ----------------------------------------------------------------------------
// Pulse trigger resampler
// Detects pulses in an envelope stream, buffers them and emits 64 resampled,
// scaled points per pulse with its length and start time.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//   input     in         in_valid/in_stall    sample
//   output    out        out_valid/out_stall  point, point_index, pulse_length,
//                                             pulse_time, overflowed, last
//
// Samples that do not close a pulse may follow back to back. A closing sample
// starts a reciprocal divide for the timestamp, then each of the 64 points
// passes through the two-port store read, the mix, the scale and the
// reciprocal divide. in_stall is high for the whole emission, and longer while
// out_stall holds. Synchronous reset clears control state; the store needs no
// clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_trigger_resampler_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // Sample input
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [15:0]  sample,
  // Point output
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [23:0]       point,
  output logic        [5:0]        point_index,
  output logic        [9:0]        pulse_length,
  output logic        [29:0]       pulse_time,
  output logic                     overflowed,
  output logic                     last
);

  localparam int Aw   = ptr_pkg::StoreAw;
  localparam int IdxW = ptr_pkg::IdxW;

  // Configuration registers.
  logic [14:0] threshold;
  logic [14:0] hysteresis;
  logic [15:0] mass_factor;
  logic [30:0] start_time;

  // Pulse tracking state.
  logic                      pulse_open;
  logic [31:0]               sample_count;
  logic [31:0]               pulse_begin;
  logic [ptr_pkg::RunW-1:0]  run_length;
  logic                      store_full;
  logic [Aw-1:0]             step_q;
  logic [IdxW-1:0]           step_r;
  logic [9:0]                plen_q;
  logic [5:0]                plen_r;

  // Sequencer and point datapath.
  ptr_pkg::seq_state_t state, state_next;
  logic [IdxW-1:0]     pt_i;
  logic [Aw-1:0]       pt_q;
  logic [IdxW-1:0]     pt_r;
  logic                num_neg;
  logic [22:0]         num_mag;
  logic [38:0]         scaled;
  logic [46:0]         pp_hi;
  logic [45:0]         pp_lo;

  logic signed [15:0]  rd_a;
  logic signed [15:0]  rd_b;
  logic [29:0]         time_q;
  logic                div_done;
  logic                div_start;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  logic                cfg_we;
  ptr_pkg::reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = ptr_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= 15'd32767;
      hysteresis  <= 15'd0;
      mass_factor <= 16'd256;
      start_time  <= 31'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ptr_pkg::REG_THRESHOLD:   threshold   <= pwdata[14:0];
        ptr_pkg::REG_HYSTERESIS:  hysteresis  <= pwdata[14:0];
        ptr_pkg::REG_MASS_FACTOR: mass_factor <= pwdata[15:0];
        ptr_pkg::REG_START_TIME:  start_time  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ptr_pkg::REG_THRESHOLD:   prdata = {17'd0, threshold};
      ptr_pkg::REG_HYSTERESIS:  prdata = {17'd0, hysteresis};
      ptr_pkg::REG_MASS_FACTOR: prdata = {16'd0, mass_factor};
      ptr_pkg::REG_START_TIME:  prdata = {1'b0, start_time};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Trigger decision for the incoming sample.
  // ---------------------------------------------------------------------------
  logic               in_take;
  logic [16:0]        mag;
  logic signed [16:0] level;
  logic               hit;
  logic               opening;
  logic               closing;

  assign in_stall = (state != ptr_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    mag     = sample[15] ? 17'(-{sample[15], sample}) : {1'b0, sample};
    level   = $signed({2'b00, threshold})
            - $signed(pulse_open ? {2'b00, hysteresis} : 17'd0);
    hit     = $signed({1'b0, mag}) > $signed({level[16], level});
    opening = hit && !pulse_open;
    closing = !hit && pulse_open;
  end

  // ---------------------------------------------------------------------------
  // Pulse bookkeeping, including the running step (len-1)/63 and the
  // running rounded length (8*len+25)/50.
  // ---------------------------------------------------------------------------
  logic [ptr_pkg::RunW-1:0] rl_base;
  logic                     can_store;
  logic                     store_we;
  logic [6:0]               plen_t;

  always_comb begin
    rl_base   = opening ? '0 : run_length;
    can_store = !rl_base[ptr_pkg::RunW-1];
    store_we  = in_take && hit && can_store;
    plen_t    = {1'b0, (opening ? 6'd25 : plen_r)} + 7'd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_open   <= 1'b0;
      sample_count <= 32'd0;
      pulse_begin  <= 32'd0;
      run_length   <= '0;
      store_full   <= 1'b0;
      step_q       <= '0;
      step_r       <= '0;
      plen_q       <= 10'd0;
      plen_r       <= 6'd25;
    end else if (in_take) begin
      sample_count <= sample_count + 32'd1;
      if (hit) begin
        pulse_open <= 1'b1;
        if (opening) begin
          pulse_begin <= sample_count + {1'b0, start_time};
        end
        if (can_store) begin
          run_length <= rl_base + 1'b1;
          store_full <= opening ? 1'b0 : store_full;
          if (rl_base == '0) begin
            step_q <= '0;
            step_r <= '0;
          end else if (step_r == IdxW'(ptr_pkg::Den - 1)) begin
            step_q <= step_q + 1'b1;
            step_r <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
          if (plen_t >= 7'd50) begin
            plen_r <= 6'(plen_t - 7'd50);
            plen_q <= (opening ? 10'd0 : plen_q) + 10'd1;
          end else begin
            plen_r <= plen_t[5:0];
            plen_q <= opening ? 10'd0 : plen_q;
          end
        end else begin
          store_full <= 1'b1;
        end
      end else if (closing) begin
        pulse_open <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample store and timestamp divider.
  // ---------------------------------------------------------------------------
  ptr_store u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (rl_base[Aw-1:0]),
    .wdata   (sample),
    .raddr_a (pt_q),
    .raddr_b (pt_q + 1'b1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign div_start = in_take && closing;

  ptr_div50 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({1'b0, pulse_begin, 3'b000} + 36'd25),
    .done     (div_done),
    .quotient (time_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  logic out_free;
  logic load_out;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ptr_pkg::S_IDLE:  if (div_start) state_next = ptr_pkg::S_DIV;
      ptr_pkg::S_DIV:   if (div_done) state_next = ptr_pkg::S_READ;
      ptr_pkg::S_READ:  state_next = ptr_pkg::S_MIX;
      ptr_pkg::S_MIX:   state_next = ptr_pkg::S_SCALE;
      ptr_pkg::S_SCALE: state_next = ptr_pkg::S_RECIP;
      ptr_pkg::S_RECIP: state_next = ptr_pkg::S_PUT;
      ptr_pkg::S_PUT: begin
        if (out_free) begin
          state_next = (pt_i == IdxW'(ptr_pkg::Den)) ? ptr_pkg::S_IDLE : ptr_pkg::S_READ;
        end
      end
      default: state_next = ptr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: outputs.
  always_comb begin
    load_out = (state == ptr_pkg::S_PUT) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Point position: i*(len-1) kept as quotient and remainder of 63.
  // ---------------------------------------------------------------------------
  logic [IdxW:0] r_sum;
  logic          r_wrap;

  always_comb begin
    r_sum  = {1'b0, pt_r} + {1'b0, step_r};
    r_wrap = (r_sum >= (IdxW + 1)'(ptr_pkg::Den));
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      pt_i <= '0;
      pt_q <= '0;
      pt_r <= '0;
    end else if (load_out) begin
      pt_i <= pt_i + 1'b1;
      pt_q <= pt_q + step_q + Aw'(r_wrap);
      pt_r <= r_wrap ? IdxW'(r_sum - (IdxW + 1)'(ptr_pkg::Den)) : r_sum[IdxW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Point datapath: mix, scale by mass factor, divide by 63*256.
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]    w_a;
  logic signed [15:0] b_sel;
  logic signed [23:0] prod_a;
  logic signed [23:0] prod_b;
  logic signed [23:0] num_sum;
  logic [30:0]        xs;
  logic [61:0]        total;
  logic [23:0]        q_mag;

  always_comb begin
    w_a     = IdxW'(ptr_pkg::Den) - pt_r;
    b_sel   = (pt_r == '0) ? 16'sd0 : rd_b;
    prod_a  = rd_a * $signed({2'b00, w_a});
    prod_b  = b_sel * $signed({2'b00, pt_r});
    num_sum = prod_a + prod_b;
    xs      = scaled[38:8];
    total   = {pp_hi, 15'd0} + {16'd0, pp_lo};
    q_mag   = total[ptr_pkg::RecipShift +: 24];
  end

  always_ff @(posedge clk) begin
    if (state == ptr_pkg::S_MIX) begin
      num_neg <= num_sum[23];
      num_mag <= num_sum[23] ? 23'(-num_sum) : num_sum[22:0];
    end
    if (state == ptr_pkg::S_SCALE) begin
      scaled <= mass_factor * num_mag;
    end
    if (state == ptr_pkg::S_RECIP) begin
      pp_hi <= xs[30:15] * ptr_pkg::Recip63;
      pp_lo <= xs[14:0] * ptr_pkg::Recip63;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point        <= num_neg ? -$signed(q_mag) : $signed(q_mag);
      point_index  <= pt_i;
      pulse_length <= plen_q;
      pulse_time   <= time_q;
      overflowed   <= store_full;
      last         <= (pt_i == IdxW'(ptr_pkg::Den));
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Pulse trigger resampler testbench
// Drives envelope samples and register writes into the resampler, predicts
// the 64 points of every closed pulse and checks each output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallMax  = 18;
  localparam int WatchMax  = 20000;
  localparam int DirectedN = 22;

  // Expected output transaction.
  typedef struct packed {
    logic signed [23:0] point;
    logic [5:0]         point_index;
    logic [9:0]         pulse_length;
    logic [29:0]        pulse_time;
    logic               overflowed;
    logic               last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] point;
  logic [5:0] point_index;
  logic [9:0] pulse_length;
  logic [29:0] pulse_time;
  logic overflowed, last;

  always #2 clk = ~clk;

  pulse_trigger_resampler_unit dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .point, .point_index, .pulse_length,
    .pulse_time, .overflowed, .last
  );

  // Predictor state and shadow registers.
  logic [14:0] thr_q, hys_q;
  logic [15:0] mass_q;
  logic [30:0] t0_q;
  logic signed [15:0] store_q [ptr_pkg::MaxPulse];
  logic open_q, full_q;
  logic [31:0] count_q, begin_q;
  logic [12:0] len_q;

  point_t exp_points [$];
  int mismatches = 0;
  int points_seen = 0;
  int pulses_done = 0;
  int samples_sent = 0;
  int idle_cycles = 0;

  // Directed samples, sent in groups between register writes; every
  // closed pulse is checked against the predictor.
  logic signed [15:0] dir_sample [DirectedN] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd0,
    16'sd200, 16'sd300, -16'sd250, 16'sd10,
    16'sd150, 16'sd5, 16'sd101, -16'sd101, 16'sd100,
    16'sd1000, 16'sd1, 16'sd0, -16'sd1, 16'sd0,
    16'sd500, -16'sd500, 16'sd32767, 16'sd0
  };

  function automatic logic [63:0] div_by_625(logic [63:0] x);
    return (x * 64'd8 + 64'd25) / 64'd50;
  endfunction

  // Interpolated and scaled value of one point.
  function automatic logic signed [23:0] resample_at(int unsigned i, int unsigned n);
    longint prod, q, r, a, b, num, v;
    prod = longint'(i) * longint'(n - 1);
    q = prod / ptr_pkg::Den;
    r = prod % ptr_pkg::Den;
    a = store_q[q % ptr_pkg::MaxPulse];
    if (r == 0) num = a * ptr_pkg::Den;
    else begin
      b = store_q[(q + 1) % ptr_pkg::MaxPulse];
      num = a * (ptr_pkg::Den - r) + b * r;
    end
    v = (longint'(mass_q) * num) / (ptr_pkg::Den * 256);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Advance the predictor by one accepted sample.
  task automatic predict_sample(logic signed [15:0] s);
    longint mag, level;
    int unsigned n;
    point_t p;
    logic [63:0] plen_w, ptime_w;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    level = longint'(thr_q) - (open_q ? longint'(hys_q) : 0);
    if (mag > level) begin
      if (!open_q) begin
        begin_q = count_q + {1'b0, t0_q};
        len_q = '0;
        full_q = 1'b0;
        open_q = 1'b1;
      end
      if (len_q < ptr_pkg::MaxPulse) begin
        store_q[len_q[11:0]] = s;
        len_q++;
      end else full_q = 1'b1;
    end else if (open_q) begin
      n = (len_q != 0) ? len_q : 1;
      plen_w = div_by_625(64'(len_q));
      ptime_w = div_by_625(64'(begin_q));
      for (int i = 0; i < ptr_pkg::OutPoints; i++) begin
        p.point = resample_at(i, n);
        p.point_index = i[5:0];
        p.pulse_length = plen_w[9:0];
        p.pulse_time = ptime_w[29:0];
        p.overflowed = full_q;
        p.last = (i == ptr_pkg::OutPoints - 1);
        exp_points.insert(exp_points.size(), p);
      end
      open_q = 1'b0;
      pulses_done++;
    end
    count_q++;
  endtask

  // Register write through setup and access cycles, idle block only.
  task automatic write_reg(ptr_pkg::reg_index_t idx, logic [31:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ptr_pkg::REG_THRESHOLD:   thr_q = value[14:0];
      ptr_pkg::REG_HYSTERESIS:  hys_q = value[14:0];
      ptr_pkg::REG_MASS_FACTOR: mass_q = value[15:0];
      ptr_pkg::REG_START_TIME:  t0_q = value[30:0];
      default: ;
    endcase
  endtask

  // Send one sample with a random gap in front of it; valid stays high
  // afterwards so that the next sample can follow without a gap.
  task automatic send_sample(logic signed [15:0] s);
    int gap;
    gap = (samples_sent % 40 < 10) ? 0 : $urandom_range(0, StallMax);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  // Wait for every expected point, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (exp_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Closes an open pulse at a nonnegative level: zero is never above it.
  task automatic random_pulse(int max_len);
    int n;
    n = $urandom_range(1, max_len);
    for (int k = 0; k < n; k++)
      send_sample(16'($urandom_range(0, 65535)) | 16'sh7000);
    send_sample(16'sd0);
  endtask

  // Output side: random stall and checking of each transaction.
  always @(posedge clk) begin
    point_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{point, point_index, pulse_length, pulse_time, overflowed, last};
      points_seen++;
      if (exp_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %0d", point_index);
      end else begin
        want = exp_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp %0d/%0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0d/%0b/%0b",
                     want.point, want.point_index, want.pulse_length, want.pulse_time,
                     want.overflowed, want.last, got.point, got.point_index,
                     got.pulse_length, got.pulse_time, got.overflowed, got.last);
        end
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && (samples_sent % 50 > 15)) stall_left <= $urandom_range(0, StallMax);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchMax) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    thr_q = 15'd32767; hys_q = '0; mass_q = 16'd256; t0_q = '0;
    open_q = 1'b0; full_q = 1'b0; count_q = '0; begin_q = '0; len_q = '0;
    foreach (store_q[k]) store_q[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: at the reset threshold only the most negative sample opens.
    for (int k = 0; k < 4; k++) send_sample(dir_sample[k]);
    drain();
    write_reg(ptr_pkg::REG_THRESHOLD, 32'd100);
    write_reg(ptr_pkg::REG_HYSTERESIS, 32'd95);
    write_reg(ptr_pkg::REG_START_TIME, 32'h7FFF_FFFF);
    write_reg(ptr_pkg::REG_MASS_FACTOR, 32'hFFFF);
    for (int k = 4; k < 13; k++) send_sample(dir_sample[k]);
    drain();
    // Level below zero: hysteresis above threshold holds pulse open.
    write_reg(ptr_pkg::REG_THRESHOLD, 32'd0);
    write_reg(ptr_pkg::REG_HYSTERESIS, 32'h7FFF);
    write_reg(ptr_pkg::REG_MASS_FACTOR, 32'd0);
    for (int k = 13; k < 18; k++) send_sample(dir_sample[k]);
    write_reg(ptr_pkg::REG_HYSTERESIS, 32'd0);
    write_reg(ptr_pkg::REG_MASS_FACTOR, 32'd256);
    write_reg(ptr_pkg::REG_START_TIME, 32'd0);
    for (int k = 18; k < DirectedN; k++) send_sample(dir_sample[k]);
    drain();

    // Random phases with changing settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ptr_pkg::REG_THRESHOLD, $urandom_range(0, 32767) & 32'h6FFF);
      write_reg(ptr_pkg::REG_HYSTERESIS, $urandom_range(0, 32767));
      write_reg(ptr_pkg::REG_MASS_FACTOR, $urandom());
      write_reg(ptr_pkg::REG_START_TIME, $urandom());
      for (int k = 0; k < 4; k++) begin
        random_pulse(5);
        send_sample(16'($urandom()));
      end
      drain();
    end

    $display("Run covered %0d samples, %0d pulses and %0d points.",
             samples_sent, pulses_done, points_seen);
    if (mismatches == 0 && exp_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
hdl/ptr_pkg.sv
hdl/ptr_store.sv
hdl/ptr_div50.sv
hdl/pulse_trigger_resampler_unit.sv
tb/tb_top.sv
